@@ rtl/core/mlfq_task_scheduler_unit_defines.svh @@
// Assertion macros for the feedback-queue scheduler checkers.
// No dependencies; included by the checker file.
`ifndef MLFQ_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define MLFQ_TASK_SCHEDULER_UNIT_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define MLFQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mlfq scheduler check failed");

// Condition that must never be seen on a rising edge outside reset.
`define MLFQ_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mlfq scheduler forbidden condition seen");

`endif

@@ rtl/core/mlfq_pkg.sv @@
// Package for the feedback-queue scheduler: sizes, codes, item structs, FSM states.
// No dependencies; used by the scheduler top level, the checker and the bench.
package mlfq_pkg;

    localparam int MAX_TASKS  = 64;
    localparam int NUM_LEVELS = 5;
    localparam int NUM_QUANTA = 5;

    localparam int TID_W  = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int LVL_W  = 3;
    localparam int K_W    = $clog2(NUM_LEVELS + 1);
    localparam int QDEPTH = NUM_LEVELS * MAX_TASKS;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int CFG_IDX_W = 3;

    localparam logic [4:0] TICK_MAX = 5'd31;
    localparam logic [4:0] QUANTUM_RESET [NUM_QUANTA] = '{5'd1, 5'd2, 5'd4, 5'd8, 5'd16};

    // opcodes
    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_PICK   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_WAKE   = 2'd3;

    // finish outcomes
    localparam logic [1:0] OUT_SLEEP = 2'd1;
    localparam logic [1:0] OUT_EXIT  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_BUSY  = 2'd1;
    localparam logic [1:0] STAT_NORUN = 2'd2;

    // per-task state codes
    localparam logic [1:0] TS_ABSENT  = 2'd0;
    localparam logic [1:0] TS_READY   = 2'd1;
    localparam logic [1:0] TS_RUNNING = 2'd2;
    localparam logic [1:0] TS_SLEEP   = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] task_id;
        logic [1:0] outcome;
        logic [7:0] channel;
    } cmd_t;

    typedef struct packed {
        logic [5:0] chosen_task;
        logic       chosen_valid;
        logic [2:0] task_level;
        logic [4:0] ticks_in_level;
        logic [6:0] woken_count;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [4:0]       ticks;
        logic [1:0]       tstat;
        logic [7:0]       channel;
    } task_ent_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CR_CHK,
        S_PK_SCAN,
        S_PK_Q,
        S_PK_T,
        S_FN_TSK,
        S_FD_SCAN,
        S_FD_CHK,
        S_FN_APPLY,
        S_RM_RD,
        S_RM_WR,
        S_FN_TAIL,
        S_WK_TSK,
        S_WK_APPLY,
        S_PH_RD,
        S_PH_WR,
        S_WK_NEXT
    } state_t;

    function automatic logic [QA_W-1:0] q_addr(input logic [LVL_W-1:0] lvl,
                                               input logic [CNT_W-1:0] idx);
        return QA_W'(int'(lvl) * MAX_TASKS + int'(idx));
    endfunction

    function automatic logic [LVL_W-1:0] level_of(input logic [LVL_W-1:0] lvl);
        return (int'(lvl) < NUM_LEVELS) ? lvl : LVL_W'(NUM_LEVELS - 1);
    endfunction

endpackage

@@ rtl/core/mlfq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/mlfq_task_scheduler_unit.sv @@
// Top level of the five-level feedback-queue task scheduler.
// Depends on mlfq_pkg and mlfq_ram.
//
// Usage:
//  - Command channel: an item (cmd) is taken on a rising edge with start high and busy
//    low. Opcodes: create, pick, finish running task, wake channel.
//  - Each item gives exactly one result: result is valid for the one cycle in which
//    done is high. The receiver cannot stall; capture it on that edge.
//  - Config channel: cfg_valid/cfg_ready with cfg_index (0..4 = quantum of level
//    0..4) and cfg_data. cfg_ready is always high; write only while idle.
//  - Timing: a pick while a task runs or a finish with none running answers
//    straight from idle. Create does one slot lookup. Pick works per queue entry
//    visited and per level crossed. Finish works per entry searched and per entry
//    shifted. Wake works per task slot (64) plus, per woken task, per entry
//    searched and per entry shifted.
//  - Run times are set by the one-read, one-write queue and task RAMs: one entry
//    read or moved per step, with a registered read in each loop.
//  - One item at a time; busy stays high until its result is shown.
//  - Reset: queues empty, all slots absent, no running task, quanta 1/2/4/8/16.
//    Task slots carry one valid bit each, cleared at once, so no clearing pass.
module mlfq_task_scheduler_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mlfq_pkg::cmd_t                   cmd,
    output logic                             done,
    output mlfq_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [4:0]                       cfg_data
);

    localparam int TW = mlfq_pkg::TID_W;
    localparam int CW = mlfq_pkg::CNT_W;
    localparam int LW = mlfq_pkg::LVL_W;

    mlfq_pkg::state_t state_reg, state_next;

    // latched item
    logic [1:0] op_reg, op_next;
    logic [1:0] outc_reg, outc_next;
    logic [7:0] ch_reg, ch_next;

    // working registers of the sequencer
    logic [TW-1:0]        cur_t_reg, cur_t_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [mlfq_pkg::K_W-1:0] k_reg, k_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 found_reg, found_next;
    logic                 push_reg, push_next;
    logic [LW-1:0]        push_lvl_reg, push_lvl_next;
    mlfq_pkg::task_ent_t  tsk_reg, tsk_next;
    logic [TW-1:0]        wt_reg, wt_next;
    logic [6:0]           woken_reg, woken_next;

    // scheduler state outside the memories
    logic [LW-1:0]   scan_level_reg, scan_level_next;
    logic [CW-1:0]   scan_index_reg, scan_index_next;
    logic [TW-1:0]   run_task_reg, run_task_next;
    logic            run_valid_reg, run_valid_next;
    logic [CW-1:0]   cnt_reg [mlfq_pkg::NUM_LEVELS];
    logic [CW-1:0]   cnt_next [mlfq_pkg::NUM_LEVELS];
    logic [4:0]      quantum_reg [mlfq_pkg::NUM_QUANTA];
    logic [4:0]      quantum_next [mlfq_pkg::NUM_QUANTA];
    logic [mlfq_pkg::MAX_TASKS-1:0] tvalid_reg, tvalid_next;
    logic            t_rvld_reg;

    mlfq_pkg::result_t res_reg, res_next;
    logic              done_reg, done_next;

    // memory ports
    logic                    q_we;
    logic [mlfq_pkg::QA_W-1:0] q_waddr, q_raddr;
    logic [TW-1:0]           q_wdata, q_rdata;
    logic                    t_we;
    logic [TW-1:0]           t_waddr, t_raddr;
    mlfq_pkg::task_ent_t     t_wdata;
    logic [$bits(mlfq_pkg::task_ent_t)-1:0] t_rdata;

    // shared decode
    mlfq_pkg::task_ent_t ent;
    logic [CW-1:0]       cnt_cur;
    logic                scan_hit;
    logic                rm_more;
    logic                wake_hit;
    logic                k_last;
    logic                wt_last;
    logic [4:0]          tk;
    logic [LW-1:0]       qidx;
    logic                demote;
    logic                bottom;
    logic                fn_shift;
    mlfq_pkg::state_t    apply_state;

    // queue entries: level * MAX_TASKS + position
    mlfq_ram #(
        .WIDTH (TW),
        .DEPTH (mlfq_pkg::QDEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // per-task level, ticks, state and channel
    mlfq_ram #(
        .WIDTH ($bits(mlfq_pkg::task_ent_t)),
        .DEPTH (mlfq_pkg::MAX_TASKS)
    ) u_task (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // a slot never written reads as absent, level 0, no ticks
    assign ent      = t_rvld_reg ? mlfq_pkg::task_ent_t'(t_rdata) : '0;
    assign cnt_cur  = cnt_reg[lvl_reg];
    assign scan_hit = idx_reg < cnt_cur;
    assign rm_more  = (idx_reg + 1'b1) < cnt_cur;
    assign wake_hit = (ent.tstat == mlfq_pkg::TS_SLEEP) && (ent.channel == ch_reg);
    assign k_last   = k_reg == mlfq_pkg::K_W'(mlfq_pkg::NUM_LEVELS);
    assign wt_last  = wt_reg == TW'(mlfq_pkg::MAX_TASKS - 1);
    assign tk       = (tsk_reg.ticks == mlfq_pkg::TICK_MAX) ? mlfq_pkg::TICK_MAX
                                                           : tsk_reg.ticks + 1'b1;
    assign qidx     = (int'(lvl_reg) < mlfq_pkg::NUM_QUANTA - 1) ? lvl_reg
                                                               : LW'(mlfq_pkg::NUM_QUANTA - 1);
    assign demote   = tk >= quantum_reg[qidx];
    assign bottom   = lvl_reg == LW'(mlfq_pkg::NUM_LEVELS - 1);
    // the finished task leaves its slot on exit, rotation or demotion only
    assign fn_shift = (outc_reg == mlfq_pkg::OUT_EXIT) || bottom || demote;
    assign apply_state = (op_reg == mlfq_pkg::OP_FINISH) ? mlfq_pkg::S_FN_APPLY
                                                         : mlfq_pkg::S_WK_APPLY;

    assign busy      = state_reg != mlfq_pkg::S_IDLE;
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mlfq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.opcode)
                        mlfq_pkg::OP_CREATE: state_next = mlfq_pkg::S_CR_CHK;
                        mlfq_pkg::OP_PICK:
                            state_next = run_valid_reg ? mlfq_pkg::S_IDLE : mlfq_pkg::S_PK_SCAN;
                        mlfq_pkg::OP_FINISH:
                            state_next = run_valid_reg ? mlfq_pkg::S_FN_TSK : mlfq_pkg::S_IDLE;
                        mlfq_pkg::OP_WAKE:   state_next = mlfq_pkg::S_WK_TSK;
                        default:             state_next = mlfq_pkg::S_IDLE;
                    endcase
                end
            end
            mlfq_pkg::S_CR_CHK:  state_next = mlfq_pkg::S_IDLE;
            mlfq_pkg::S_PK_SCAN:
            begin
                if (scan_hit)
                    state_next = mlfq_pkg::S_PK_Q;
                else if (k_last)
                    state_next = mlfq_pkg::S_IDLE;
            end
            mlfq_pkg::S_PK_Q:    state_next = mlfq_pkg::S_PK_T;
            mlfq_pkg::S_PK_T:
                state_next = (ent.tstat == mlfq_pkg::TS_READY) ? mlfq_pkg::S_IDLE
                                                               : mlfq_pkg::S_PK_SCAN;
            mlfq_pkg::S_FN_TSK:  state_next = mlfq_pkg::S_FD_SCAN;
            mlfq_pkg::S_FD_SCAN: state_next = scan_hit ? mlfq_pkg::S_FD_CHK : apply_state;
            mlfq_pkg::S_FD_CHK:
                state_next = (q_rdata == cur_t_reg) ? apply_state : mlfq_pkg::S_FD_SCAN;
            mlfq_pkg::S_FN_APPLY:
                state_next = (found_reg && fn_shift) ? mlfq_pkg::S_RM_RD : mlfq_pkg::S_FN_TAIL;
            mlfq_pkg::S_RM_RD:
                state_next = rm_more ? mlfq_pkg::S_RM_WR : mlfq_pkg::S_FN_TAIL;
            mlfq_pkg::S_RM_WR:   state_next = mlfq_pkg::S_RM_RD;
            mlfq_pkg::S_FN_TAIL: state_next = mlfq_pkg::S_IDLE;
            mlfq_pkg::S_WK_TSK:
                state_next = wake_hit ? mlfq_pkg::S_FD_SCAN : mlfq_pkg::S_WK_NEXT;
            mlfq_pkg::S_WK_APPLY:
                state_next = (!found_reg && cnt_cur == CW'(mlfq_pkg::MAX_TASKS))
                             ? mlfq_pkg::S_WK_NEXT : mlfq_pkg::S_PH_RD;
            mlfq_pkg::S_PH_RD:
                state_next = (idx_reg == '0) ? mlfq_pkg::S_WK_NEXT : mlfq_pkg::S_PH_WR;
            mlfq_pkg::S_PH_WR:   state_next = mlfq_pkg::S_PH_RD;
            mlfq_pkg::S_WK_NEXT:
                state_next = wt_last ? mlfq_pkg::S_IDLE : mlfq_pkg::S_WK_TSK;
            default:             state_next = mlfq_pkg::S_IDLE;
        endcase
    end

    // datapath, memory controls and results
    always_comb
    begin
        op_next         = op_reg;
        outc_next       = outc_reg;
        ch_next         = ch_reg;
        cur_t_next      = cur_t_reg;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        push_next       = push_reg;
        push_lvl_next   = push_lvl_reg;
        tsk_next        = tsk_reg;
        wt_next         = wt_reg;
        woken_next      = woken_reg;
        scan_level_next = scan_level_reg;
        scan_index_next = scan_index_reg;
        run_task_next   = run_task_reg;
        run_valid_next  = run_valid_reg;
        cnt_next        = cnt_reg;
        quantum_next    = quantum_reg;
        tvalid_next     = tvalid_reg;
        res_next        = res_reg;
        done_next       = 1'b0;

        q_we    = 1'b0;
        q_waddr = mlfq_pkg::q_addr(lvl_reg, idx_reg);
        q_wdata = q_rdata;
        q_raddr = mlfq_pkg::q_addr(lvl_reg, idx_reg);
        t_we    = 1'b0;
        t_waddr = cur_t_reg;
        t_wdata = tsk_reg;
        t_raddr = cur_t_reg;

        if (cfg_valid && int'(cfg_index) < mlfq_pkg::NUM_QUANTA)
        begin
            quantum_next[cfg_index] = cfg_data;
        end

        unique case (state_reg)
            mlfq_pkg::S_IDLE:
            begin
                op_next   = cmd.opcode;
                outc_next = cmd.outcome;
                ch_next   = cmd.channel;
                res_next  = '0;
                unique case (cmd.opcode)
                    mlfq_pkg::OP_CREATE:
                    begin
                        cur_t_next = TW'(cmd.task_id);
                        t_raddr    = TW'(cmd.task_id);
                    end
                    mlfq_pkg::OP_PICK:
                    begin
                        lvl_next = scan_level_reg;
                        idx_next = scan_index_reg;
                        k_next   = '0;
                        if (start && run_valid_reg)
                        begin
                            res_next.status = mlfq_pkg::STAT_BUSY;
                            done_next       = 1'b1;
                        end
                    end
                    mlfq_pkg::OP_FINISH:
                    begin
                        cur_t_next = run_task_reg;
                        t_raddr    = run_task_reg;
                        if (start && !run_valid_reg)
                        begin
                            res_next.status = mlfq_pkg::STAT_NORUN;
                            done_next       = 1'b1;
                        end
                    end
                    mlfq_pkg::OP_WAKE:
                    begin
                        wt_next    = '0;
                        woken_next = '0;
                        t_raddr    = '0;
                    end
                    default:
                    begin
                        t_raddr = '0;
                    end
                endcase
            end

            mlfq_pkg::S_CR_CHK:
            begin
                done_next = 1'b1;
                if (ent.tstat == mlfq_pkg::TS_ABSENT
                    && cnt_reg[0] < CW'(mlfq_pkg::MAX_TASKS)
                    && int'(cur_t_reg) < mlfq_pkg::MAX_TASKS)
                begin
                    t_we                  = 1'b1;
                    t_wdata               = '{level: '0, ticks: '0,
                                              tstat: mlfq_pkg::TS_READY,
                                              channel: ent.channel};
                    tvalid_next[cur_t_reg] = 1'b1;
                    q_we                  = 1'b1;
                    q_waddr               = mlfq_pkg::q_addr('0, cnt_reg[0]);
                    q_wdata               = cur_t_reg;
                    cnt_next[0]           = cnt_reg[0] + 1'b1;
                    res_next.chosen_task  = 6'(cur_t_reg);
                    res_next.chosen_valid = 1'b1;
                end
                else
                begin
                    res_next.status = mlfq_pkg::STAT_BUSY;
                end
            end

            mlfq_pkg::S_PK_SCAN:
            begin
                if (!scan_hit)
                begin
                    if (k_last)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        k_next   = k_reg + 1'b1;
                        idx_next = '0;
                        lvl_next = (lvl_reg == LW'(mlfq_pkg::NUM_LEVELS - 1)) ? '0
                                                                              : lvl_reg + 1'b1;
                    end
                end
            end

            mlfq_pkg::S_PK_Q:
            begin
                cur_t_next = q_rdata;
                t_raddr    = q_rdata;
            end

            mlfq_pkg::S_PK_T:
            begin
                if (ent.tstat == mlfq_pkg::TS_READY)
                begin
                    t_we                     = 1'b1;
                    t_wdata                  = ent;
                    t_wdata.tstat            = mlfq_pkg::TS_RUNNING;
                    tvalid_next[cur_t_reg]   = 1'b1;
                    run_task_next            = cur_t_reg;
                    run_valid_next           = 1'b1;
                    scan_level_next          = lvl_reg;
                    scan_index_next          = idx_reg;
                    res_next.chosen_task     = 6'(cur_t_reg);
                    res_next.chosen_valid    = 1'b1;
                    res_next.task_level      = mlfq_pkg::level_of(ent.level);
                    res_next.ticks_in_level  = ent.ticks;
                    done_next                = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            mlfq_pkg::S_FN_TSK:
            begin
                tsk_next   = ent;
                lvl_next   = mlfq_pkg::level_of(ent.level);
                idx_next   = '0;
                found_next = 1'b0;
            end

            mlfq_pkg::S_FD_CHK:
            begin
                if (q_rdata == cur_t_reg)
                begin
                    pos_next   = idx_reg;
                    found_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            mlfq_pkg::S_FN_APPLY:
            begin
                t_we                  = 1'b1;
                tvalid_next[cur_t_reg] = 1'b1;
                run_valid_next        = 1'b0;
                idx_next              = pos_reg;
                push_next             = 1'b0;
                push_lvl_next         = lvl_reg;
                res_next              = '0;
                res_next.chosen_task  = 6'(cur_t_reg);
                res_next.chosen_valid = 1'b1;
                res_next.task_level   = lvl_reg;
                res_next.ticks_in_level = tk;
                t_wdata               = tsk_reg;
                t_wdata.ticks         = tk;
                if (outc_reg == mlfq_pkg::OUT_EXIT)
                begin
                    t_wdata.tstat = mlfq_pkg::TS_ABSENT;
                    if (found_reg)
                    begin
                        scan_level_next = lvl_reg;
                        scan_index_next = pos_reg;
                    end
                end
                else
                begin
                    if (outc_reg == mlfq_pkg::OUT_SLEEP)
                    begin
                        t_wdata.tstat   = mlfq_pkg::TS_SLEEP;
                        t_wdata.channel = ch_reg;
                    end
                    else
                    begin
                        t_wdata.tstat = mlfq_pkg::TS_READY;
                    end
                    if (bottom)
                    begin
                        // rotate to the tail; the pass restarts at the top
                        push_next       = found_reg;
                        scan_level_next = '0;
                        scan_index_next = '0;
                    end
                    else if (demote)
                    begin
                        push_next       = 1'b1;
                        push_lvl_next   = lvl_reg + 1'b1;
                        t_wdata.level   = lvl_reg + 1'b1;
                        t_wdata.ticks   = '0;
                        res_next.task_level     = lvl_reg + 1'b1;
                        res_next.ticks_in_level = '0;
                        if (found_reg)
                        begin
                            scan_level_next = lvl_reg;
                            scan_index_next = pos_reg;
                        end
                    end
                    else if (found_reg)
                    begin
                        scan_level_next = lvl_reg;
                        scan_index_next = pos_reg + 1'b1;
                    end
                end
            end

            mlfq_pkg::S_RM_RD:
            begin
                q_raddr = mlfq_pkg::q_addr(lvl_reg, idx_reg + 1'b1);
                if (!rm_more)
                begin
                    cnt_next[lvl_reg] = cnt_cur - 1'b1;
                end
            end

            mlfq_pkg::S_RM_WR:
            begin
                q_we     = 1'b1;
                q_wdata  = q_rdata;
                idx_next = idx_reg + 1'b1;
            end

            mlfq_pkg::S_FN_TAIL:
            begin
                done_next = 1'b1;
                if (push_reg && cnt_reg[push_lvl_reg] < CW'(mlfq_pkg::MAX_TASKS))
                begin
                    q_we                   = 1'b1;
                    q_waddr                = mlfq_pkg::q_addr(push_lvl_reg,
                                                              cnt_reg[push_lvl_reg]);
                    q_wdata                = cur_t_reg;
                    cnt_next[push_lvl_reg] = cnt_reg[push_lvl_reg] + 1'b1;
                end
            end

            mlfq_pkg::S_WK_TSK:
            begin
                cur_t_next = wt_reg;
                tsk_next   = ent;
                lvl_next   = mlfq_pkg::level_of(ent.level);
                idx_next   = '0;
                found_next = 1'b0;
            end

            mlfq_pkg::S_WK_APPLY:
            begin
                t_we                   = 1'b1;
                t_wdata                = tsk_reg;
                t_wdata.ticks          = '0;
                t_wdata.tstat          = mlfq_pkg::TS_READY;
                tvalid_next[cur_t_reg] = 1'b1;
                woken_next             = woken_reg + 1'b1;
                // remove plus push to head: shift entries between head and old slot one place toward the tail
                if (found_reg)
                begin
                    idx_next = pos_reg;
                end
                else
                begin
                    idx_next = cnt_cur;
                    if (cnt_cur < CW'(mlfq_pkg::MAX_TASKS))
                    begin
                        cnt_next[lvl_reg] = cnt_cur + 1'b1;
                    end
                end
            end

            mlfq_pkg::S_PH_RD:
            begin
                q_raddr = mlfq_pkg::q_addr(lvl_reg, idx_reg - 1'b1);
                if (idx_reg == '0)
                begin
                    q_we    = 1'b1;
                    q_wdata = cur_t_reg;
                end
            end

            mlfq_pkg::S_PH_WR:
            begin
                q_we     = 1'b1;
                q_wdata  = q_rdata;
                idx_next = idx_reg - 1'b1;
            end

            mlfq_pkg::S_WK_NEXT:
            begin
                wt_next = wt_reg + 1'b1;
                t_raddr = wt_reg + 1'b1;
                if (wt_last)
                begin
                    res_next              = '0;
                    res_next.chosen_valid = 1'b1;
                    res_next.woken_count  = woken_reg;
                    done_next             = 1'b1;
                end
            end

            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mlfq_pkg::S_IDLE;
            scan_level_reg <= '0;
            scan_index_reg <= '0;
            run_task_reg   <= '0;
            run_valid_reg  <= 1'b0;
            tvalid_reg     <= '0;
            done_reg       <= 1'b0;
            for (int i = 0; i < mlfq_pkg::NUM_LEVELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            for (int i = 0; i < mlfq_pkg::NUM_QUANTA; i++)
            begin
                quantum_reg[i] <= mlfq_pkg::QUANTUM_RESET[i];
            end
        end
        else
        begin
            state_reg      <= state_next;
            scan_level_reg <= scan_level_next;
            scan_index_reg <= scan_index_next;
            run_task_reg   <= run_task_next;
            run_valid_reg  <= run_valid_next;
            tvalid_reg     <= tvalid_next;
            done_reg       <= done_next;
            cnt_reg        <= cnt_next;
            quantum_reg    <= quantum_next;
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        outc_reg     <= outc_next;
        ch_reg       <= ch_next;
        cur_t_reg    <= cur_t_next;
        lvl_reg      <= lvl_next;
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        push_reg     <= push_next;
        push_lvl_reg <= push_lvl_next;
        tsk_reg      <= tsk_next;
        wt_reg       <= wt_next;
        woken_reg    <= woken_next;
        res_reg      <= res_next;
        t_rvld_reg   <= tvalid_reg[t_raddr];
    end

endmodule

@@ rtl/core/mlfq_sva.sv @@
// Port-level checker for the feedback-queue scheduler, bound to the top level.
// Depends on mlfq_pkg and mlfq_task_scheduler_unit_defines.svh.
`include "mlfq_task_scheduler_unit_defines.svh"

module mlfq_sva (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input mlfq_pkg::cmd_t    cmd,
    input logic              done,
    input mlfq_pkg::result_t result
);

    // a create always needs its slot lookup before answering
    `MLFQ_ASSERT(a_create_busy, start && !busy && cmd.opcode == mlfq_pkg::OP_CREATE |=> busy && !done)
    // an applied item never reports an error
    `MLFQ_NEVER(a_valid_ok, done && result.chosen_valid && result.status != mlfq_pkg::STAT_OK)
    // woken tasks only come from a wake, which names no task
    `MLFQ_ASSERT(a_wake_res, done && result.woken_count != '0 |-> result.chosen_valid && result.chosen_task == '0)

endmodule

bind mlfq_task_scheduler_unit mlfq_sva u_mlfq_sva (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

@@ test/mlfq_task_scheduler_unit_tb.sv @@
// Self-checking bench for the feedback-queue task scheduler: drives create, pick,
// finish and wake items and checks each result against an in-bench scheduler model.
// Depends on mlfq_pkg and the mlfq_task_scheduler_unit RTL.
module mlfq_task_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 40000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    mlfq_pkg::cmd_t cmd = '0;
    logic done;
    mlfq_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [4:0] cfg_data = '0;

    mlfq_task_scheduler_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Scheduler model: five FIFO levels, per-task state, scan position
    // ---------------------------------------------------------------
    logic [4:0] quanta [mlfq_pkg::NUM_QUANTA];
    int         lvl_q [mlfq_pkg::NUM_LEVELS][$];
    logic [2:0] tsk_lvl [mlfq_pkg::MAX_TASKS];
    logic [4:0] tsk_ticks [mlfq_pkg::MAX_TASKS];
    logic [1:0] tsk_state [mlfq_pkg::MAX_TASKS];
    logic [7:0] tsk_chan [mlfq_pkg::MAX_TASKS];
    int         scan_lvl, scan_idx, run_tsk;
    bit         run_vld;

    mlfq_pkg::result_t expected_results [$];
    mlfq_pkg::cmd_t    pending_cmds [$];
    int      mismatches = 0;
    bit      failed = 1'b0;
    int      cycles = 0;

    function automatic int find_in_level(int l, int t);
        foreach (lvl_q[l][i])
            if (lvl_q[l][i] == t)
                return i;
        return -1;
    endfunction

    function automatic mlfq_pkg::result_t schedule_step(mlfq_pkg::cmd_t c);
        mlfq_pkg::result_t r;
        r = '0;
        case (c.opcode)
            mlfq_pkg::OP_CREATE:
            begin
                if (tsk_state[c.task_id] != mlfq_pkg::TS_ABSENT
                    || lvl_q[0].size() >= mlfq_pkg::MAX_TASKS)
                    r.status = mlfq_pkg::STAT_BUSY;
                else
                begin
                    tsk_state[c.task_id] = mlfq_pkg::TS_READY;
                    tsk_lvl[c.task_id] = '0;
                    tsk_ticks[c.task_id] = '0;
                    lvl_q[0].push_back(int'(c.task_id));
                    r.chosen_task = c.task_id;
                    r.chosen_valid = 1'b1;
                end
            end
            mlfq_pkg::OP_PICK:
            begin
                if (run_vld)
                    r.status = mlfq_pkg::STAT_BUSY;
                else
                begin
                    bit found;
                    found = 1'b0;
                    for (int k = 0; k <= mlfq_pkg::NUM_LEVELS && !found; k++)
                    begin
                        int l;
                        l = (scan_lvl + k) % mlfq_pkg::NUM_LEVELS;
                        for (int i = (k == 0) ? scan_idx : 0; i < lvl_q[l].size(); i++)
                        begin
                            int t;
                            t = lvl_q[l][i];
                            if (tsk_state[t] == mlfq_pkg::TS_READY)
                            begin
                                tsk_state[t] = mlfq_pkg::TS_RUNNING;
                                run_tsk = t;
                                run_vld = 1'b1;
                                scan_lvl = l;
                                scan_idx = i;
                                r.chosen_task = 6'(t);
                                r.chosen_valid = 1'b1;
                                r.task_level = tsk_lvl[t];
                                r.ticks_in_level = tsk_ticks[t];
                                found = 1'b1;
                                break;
                            end
                        end
                    end
                end
            end
            mlfq_pkg::OP_FINISH:
            begin
                if (!run_vld)
                    r.status = mlfq_pkg::STAT_NORUN;
                else
                begin
                    int t, l, pos;
                    t = run_tsk;
                    l = int'(tsk_lvl[t]);
                    pos = find_in_level(l, t);
                    if (tsk_ticks[t] < 5'd31)
                        tsk_ticks[t]++;
                    run_vld = 1'b0;
                    r.chosen_task = 6'(t);
                    r.chosen_valid = 1'b1;
                    if (c.outcome == mlfq_pkg::OUT_EXIT)
                    begin
                        r.task_level = 3'(l);
                        r.ticks_in_level = tsk_ticks[t];
                        tsk_state[t] = mlfq_pkg::TS_ABSENT;
                        if (pos >= 0)
                        begin
                            lvl_q[l].delete(pos);
                            scan_lvl = l;
                            scan_idx = pos;
                        end
                    end
                    else
                    begin
                        if (c.outcome == mlfq_pkg::OUT_SLEEP)
                        begin
                            tsk_state[t] = mlfq_pkg::TS_SLEEP;
                            tsk_chan[t] = c.channel;
                        end
                        else
                            tsk_state[t] = mlfq_pkg::TS_READY;   // yield, and outcome 3 alike
                        if (l == mlfq_pkg::NUM_LEVELS - 1)
                        begin
                            // bottom level: rotate and restart the pass
                            if (pos >= 0)
                            begin
                                lvl_q[l].delete(pos);
                                lvl_q[l].push_back(t);
                            end
                            scan_lvl = 0;
                            scan_idx = 0;
                        end
                        else if (tsk_ticks[t] >= quanta[l])
                        begin
                            if (pos >= 0)
                            begin
                                lvl_q[l].delete(pos);
                                scan_lvl = l;
                                scan_idx = pos;
                            end
                            lvl_q[l + 1].push_back(t);
                            tsk_lvl[t] = 3'(l + 1);
                            tsk_ticks[t] = '0;
                        end
                        else if (pos >= 0)
                        begin
                            scan_lvl = l;
                            scan_idx = pos + 1;
                        end
                        r.task_level = tsk_lvl[t];
                        r.ticks_in_level = tsk_ticks[t];
                    end
                end
            end
            default:
            begin
                // wake: every sleeper on the channel goes to its level's head
                for (int t = 0; t < mlfq_pkg::MAX_TASKS; t++)
                    if (tsk_state[t] == mlfq_pkg::TS_SLEEP && tsk_chan[t] == c.channel)
                    begin
                        int pos;
                        pos = find_in_level(int'(tsk_lvl[t]), t);
                        tsk_state[t] = mlfq_pkg::TS_READY;
                        tsk_ticks[t] = '0;
                        if (pos >= 0)
                            lvl_q[tsk_lvl[t]].delete(pos);
                        lvl_q[tsk_lvl[t]].push_front(t);
                        r.woken_count++;
                    end
                r.chosen_valid = 1'b1;
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driver: pops pending items, random gaps between them
    // ---------------------------------------------------------------
    int gap = 0;
    bit hold_drain = 1'b0;   // when set, wait for all results before next item

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(schedule_step(cmd));
                void'(pending_cmds.pop_front());
                gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(0, 2);
                start <= 1'b0;
            end
            else if (!start)
            begin
                if (gap > 0)
                    gap <= gap - 1;
                else if (pending_cmds.size() > 0 &&
                         !(hold_drain && expected_results.size() > 0))
                begin
                    cmd <= pending_cmds[0];
                    start <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each strobed result with the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                failed <= 1'b1;
                if (mismatches < 10)
                    $display("unexpected result %p", result);
                mismatches <= mismatches + 1;
            end
            else
            begin
                mlfq_pkg::result_t e;
                e = expected_results.pop_front();
                if (result !== e)
                begin
                    failed <= 1'b1;
                    if (mismatches < 10)
                        $display("mismatch: expected %p got %p", e, result);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic mlfq_pkg::cmd_t mk(int op, int id, int oc, int ch);
        mlfq_pkg::cmd_t c;
        c.opcode = 2'(op);
        c.task_id = 6'(id);
        c.outcome = 2'(oc);
        c.channel = 8'(ch);
        return c;
    endfunction

    task automatic drain_results();
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_quantum(int idx, logic [4:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= mlfq_pkg::CFG_IDX_W'(idx);
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        quanta[idx] = val;
        cfg_valid <= 1'b0;
    endtask

    // random bursts of picks and finishes, with some creates and wakes mixed in
    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            int sel;
            sel = $urandom_range(0, 99);
            if (sel < 12)
                pending_cmds.push_back(mk(mlfq_pkg::OP_CREATE, $urandom_range(0, 63),
                                          $urandom, $urandom));
            else if (sel < 50)
                pending_cmds.push_back(mk(mlfq_pkg::OP_PICK, $urandom, $urandom, $urandom));
            else if (sel < 85)
                // small channel range so wakes find sleepers
                pending_cmds.push_back(mk(mlfq_pkg::OP_FINISH, $urandom, $urandom_range(0, 3),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3)));
            else
                pending_cmds.push_back(mk(mlfq_pkg::OP_WAKE, $urandom, $urandom,
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        for (int i = 0; i < mlfq_pkg::NUM_QUANTA; i++)
            quanta[i] = mlfq_pkg::QUANTUM_RESET[i];
        for (int t = 0; t < mlfq_pkg::MAX_TASKS; t++)
        begin
            tsk_lvl[t] = '0;
            tsk_ticks[t] = '0;
            tsk_state[t] = mlfq_pkg::TS_ABSENT;
            tsk_chan[t] = '0;
        end
        scan_lvl = 0;
        scan_idx = 0;
        run_tsk = 0;
        run_vld = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: errors on empty scheduler, slot extremes, busy create,
        // pick while running, every finish outcome, demotion, wake
        pending_cmds.push_back(mk(mlfq_pkg::OP_FINISH, 0, 0, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_PICK, 0, 0, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_WAKE, 0, 0, 8'hff));
        pending_cmds.push_back(mk(mlfq_pkg::OP_CREATE, 0, 0, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_CREATE, 63, 3, 8'hff));
        pending_cmds.push_back(mk(mlfq_pkg::OP_CREATE, 63, 0, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_CREATE, 21, 0, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_PICK, 63, 3, 8'hff));
        pending_cmds.push_back(mk(mlfq_pkg::OP_PICK, 0, 0, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_FINISH, 0, 0, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_PICK, 0, 0, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_FINISH, 0, mlfq_pkg::OUT_SLEEP, 8'hff));
        pending_cmds.push_back(mk(mlfq_pkg::OP_PICK, 0, 0, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_FINISH, 0, 3, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_PICK, 0, 0, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_FINISH, 0, mlfq_pkg::OUT_EXIT, 0));
        pending_cmds.push_back(mk(mlfq_pkg::OP_WAKE, 0, 0, 8'hff));
        pending_cmds.push_back(mk(mlfq_pkg::OP_WAKE, 0, 0, 8'hff));
        for (int i = 0; i < 3; i++)
        begin
            pending_cmds.push_back(mk(mlfq_pkg::OP_PICK, 0, 0, 0));
            pending_cmds.push_back(mk(mlfq_pkg::OP_FINISH, 0, 0, 0));
        end
        drain_results();

        // random run at the other quantum extreme, with the sender held
        // off until every result is back
        for (int i = 0; i < mlfq_pkg::NUM_QUANTA; i++)
            write_quantum(i, 5'd31);
        hold_drain = 1'b1;
        queue_random(60);
        drain_results();
        hold_drain = 1'b0;

        // random phases over several quantum settings
        for (int ph = 0; ph < 5; ph++)
        begin
            for (int i = 0; i < mlfq_pkg::NUM_QUANTA; i++)
                case (ph)
                    0: write_quantum(i, 5'd1);
                    1: write_quantum(i, 5'd0);
                    2: write_quantum(i, mlfq_pkg::QUANTUM_RESET[i]);
                    default: write_quantum(i, 5'($urandom_range(0, 31)));
                endcase
            // a few creates first so the queues are populated
            for (int i = 0; i < 12; i++)
                pending_cmds.push_back(mk(mlfq_pkg::OP_CREATE, $urandom_range(0, 63), 0, 0));
            queue_random(100);
            drain_results();
        end

        if (!failed && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
